### sv/pld_pkg.sv
// package for the printer link packet deframer
// types and constants shared by the front, the queue, the back and the top level
`timescale 1ns / 1ps
`default_nettype none

package pld_pkg;

    localparam logic [7:0]  MARK_BYTE     = 8'h24;
    localparam logic [7:0]  CMD_CHANNEL   = 8'h01;
    localparam logic [15:0] SPEC_EXTENDED = 16'h0186;
    localparam logic [15:0] HDR_BYTES     = 16'd8;
    localparam logic [15:0] EXT_HDR_TOTAL = 16'd16;

    localparam int          Q_DEPTH   = 2;
    localparam int          Q_PTR_W   = 1;
    localparam int          Q_CNT_W   = 2;

    localparam logic [2:0]  FC_SPEC_LO = 3'd1;
    localparam logic [2:0]  FC_REF_LO  = 3'd3;
    localparam logic [2:0]  FC_PRIO    = 3'd4;
    localparam logic [2:0]  FC_DLEN_HI = 3'd6;
    localparam logic [2:0]  FC_CONS_LO = 3'd3;
    localparam logic [2:0]  FC_LAST    = 3'd7;

    typedef enum logic [2:0] {
        PH_MARK,
        PH_CHAN,
        PH_LEN,
        PH_HDR,
        PH_EXT,
        PH_CMD,
        PH_RAW,
        PH_ERR
    } t_phase;

    typedef enum logic [2:0] {
        KIND_SYNC_ERR,
        KIND_MARK,
        KIND_CHAN,
        KIND_LEN,
        KIND_HDR,
        KIND_EXT,
        KIND_CMD,
        KIND_RAW
    } t_kind;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_CHAN,
        OP_LEN,
        OP_SPEC,
        OP_REF,
        OP_PRIO,
        OP_DLEN_SHIFT,
        OP_DLEN_LOAD,
        OP_CONS
    } t_fld_op;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        t_fld_op     op;
        logic [15:0] value;
        logic        set_ext;
        logic        hdone;
        logic        last;
    } t_word_op;

endpackage

`default_nettype wire

### sv/pld_front.sv
// front of the deframer: tracks the packet phase and classifies each word
// turns every accepted word into a register update for the back; uses pld_pkg
`timescale 1ns / 1ps
`default_nettype none

module pld_front
    import pld_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire logic [7:0] i_byte,
    output t_word_op      o_op
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_fc, n_fc;
    logic [15:0] r_left, n_left;
    logic [15:0] r_len, n_len;
    logic [15:0] r_spec, n_spec;
    logic [15:0] r_dlen, n_dlen;
    logic        r_is_cmd, n_is_cmd;

    logic [15:0] w_len_sh;
    logic [15:0] w_dlen_sh;
    logic [15:0] w_body;
    logic [15:0] w_ext_cnt;
    logic        w_ext_need;

    assign w_len_sh   = {r_len[7:0], i_byte};
    assign w_dlen_sh  = {r_dlen[7:0], i_byte};
    assign w_body     = r_len - HDR_BYTES;
    assign w_ext_cnt  = (r_len >= EXT_HDR_TOTAL) ? (r_len - EXT_HDR_TOTAL) : 16'd0;
    assign w_ext_need = (w_dlen_sh != w_body) || (r_spec == SPEC_EXTENDED);

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_fc     = r_fc;
        n_left   = r_left;
        n_len    = r_len;
        n_spec   = r_spec;
        n_dlen   = r_dlen;
        n_is_cmd = r_is_cmd;
        unique case (r_phase)
            PH_MARK: begin
                if (i_byte == MARK_BYTE) begin
                    n_phase  = PH_CHAN;
                    n_fc     = 3'd0;
                    n_left   = 16'd0;
                    n_len    = 16'd0;
                    n_spec   = 16'd0;
                    n_dlen   = 16'd0;
                    n_is_cmd = 1'b0;
                end else begin
                    n_phase = PH_ERR;
                end
            end
            PH_CHAN: begin
                n_is_cmd = (i_byte == CMD_CHANNEL);
                n_fc     = 3'd0;
                n_phase  = PH_LEN;
            end
            PH_LEN: begin
                n_len = w_len_sh;
                if (r_fc == 3'd0) begin
                    n_fc = 3'd1;
                end else begin
                    n_fc = 3'd0;
                    if (r_is_cmd && (w_len_sh >= HDR_BYTES)) begin
                        n_phase = PH_HDR;
                    end else if (w_len_sh == 16'd0) begin
                        n_phase = PH_MARK;
                        n_left  = 16'd0;
                    end else begin
                        n_phase = PH_RAW;
                        n_left  = w_len_sh;
                    end
                end
            end
            PH_HDR: begin
                if (r_fc <= FC_SPEC_LO) begin
                    n_spec = {r_spec[7:0], i_byte};
                end
                if (r_fc >= FC_DLEN_HI) begin
                    n_dlen = w_dlen_sh;
                end
                if (r_fc == FC_LAST) begin
                    n_fc = 3'd0;
                    if (w_ext_need) begin
                        n_phase = PH_EXT;
                    end else if (w_body == 16'd0) begin
                        n_phase = PH_MARK;
                        n_left  = 16'd0;
                    end else begin
                        n_phase = PH_CMD;
                        n_left  = w_body;
                    end
                end else begin
                    n_fc = r_fc + 3'd1;
                end
            end
            PH_EXT: begin
                if (r_fc == FC_LAST) begin
                    n_fc   = 3'd0;
                    n_dlen = w_ext_cnt;
                    if (w_ext_cnt == 16'd0) begin
                        n_phase = PH_MARK;
                        n_left  = 16'd0;
                    end else begin
                        n_phase = PH_CMD;
                        n_left  = w_ext_cnt;
                    end
                end else begin
                    n_fc = r_fc + 3'd1;
                end
            end
            PH_CMD, PH_RAW: begin
                if (r_left <= 16'd1) begin
                    n_left  = 16'd0;
                    n_phase = PH_MARK;
                end else begin
                    n_left = r_left - 16'd1;
                end
            end
            PH_ERR: begin
                n_phase = PH_ERR;
            end
            default: begin
                n_phase = PH_ERR;
            end
        endcase
    end

    // word classification
    always_comb begin
        o_op.kind    = KIND_SYNC_ERR;
        o_op.data    = i_byte;
        o_op.op      = OP_NONE;
        o_op.value   = 16'd0;
        o_op.set_ext = 1'b0;
        o_op.hdone   = 1'b0;
        o_op.last    = 1'b0;
        unique case (r_phase)
            PH_MARK: begin
                if (i_byte == MARK_BYTE) begin
                    o_op.kind = KIND_MARK;
                    o_op.op   = OP_CLEAR;
                end
            end
            PH_CHAN: begin
                o_op.kind = KIND_CHAN;
                o_op.op   = OP_CHAN;
            end
            PH_LEN: begin
                o_op.kind = KIND_LEN;
                o_op.op   = OP_LEN;
                if ((r_fc != 3'd0) && !(r_is_cmd && (w_len_sh >= HDR_BYTES))) begin
                    o_op.hdone = 1'b1;
                    o_op.last  = (w_len_sh == 16'd0);
                end
            end
            PH_HDR: begin
                o_op.kind = KIND_HDR;
                if (r_fc <= FC_SPEC_LO) begin
                    o_op.op = OP_SPEC;
                end else if (r_fc <= FC_REF_LO) begin
                    o_op.op = OP_REF;
                end else if (r_fc == FC_PRIO) begin
                    o_op.op = OP_PRIO;
                end else if (r_fc >= FC_DLEN_HI) begin
                    o_op.op = OP_DLEN_SHIFT;
                end
                if (r_fc == FC_LAST) begin
                    if (w_ext_need) begin
                        o_op.set_ext = 1'b1;
                    end else begin
                        o_op.hdone = 1'b1;
                        o_op.last  = (w_body == 16'd0);
                    end
                end
            end
            PH_EXT: begin
                o_op.kind = KIND_EXT;
                if (r_fc <= FC_CONS_LO) begin
                    o_op.op = OP_CONS;
                end
                if (r_fc == FC_LAST) begin
                    o_op.op    = OP_DLEN_LOAD;
                    o_op.value = w_ext_cnt;
                    o_op.hdone = 1'b1;
                    o_op.last  = (w_ext_cnt == 16'd0);
                end
            end
            PH_CMD, PH_RAW: begin
                o_op.kind = (r_phase == PH_CMD) ? KIND_CMD : KIND_RAW;
                o_op.last = (r_left <= 16'd1);
            end
            PH_ERR: begin
                o_op.kind = KIND_SYNC_ERR;
            end
            default: begin
                o_op.kind = KIND_SYNC_ERR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MARK;
            r_fc     <= 3'd0;
            r_left   <= 16'd0;
            r_len    <= 16'd0;
            r_spec   <= 16'd0;
            r_dlen   <= 16'd0;
            r_is_cmd <= 1'b0;
        end else if (i_push) begin
            r_phase  <= n_phase;
            r_fc     <= n_fc;
            r_left   <= n_left;
            r_len    <= n_len;
            r_spec   <= n_spec;
            r_dlen   <= n_dlen;
            r_is_cmd <= n_is_cmd;
        end
    end

endmodule

`default_nettype wire

### sv/pld_queue.sv
// two-entry queue of classified words between front and back
// lets either side stall on its own; uses pld_pkg
`timescale 1ns / 1ps
`default_nettype none

module pld_queue
    import pld_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_word_op i_data,
    input  wire logic     i_pop,
    output t_word_op      o_data,
    output logic          o_valid,
    output logic          o_full
);

    t_word_op             r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr, r_rd;
    logic [Q_CNT_W-1:0]   r_count;

    assign o_data  = r_slot[r_rd];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/pld_back.sv
// back of the deframer: applies each classified word to the header registers
// and holds the result word until it is taken; uses pld_pkg
`timescale 1ns / 1ps
`default_nettype none

module pld_back
    import pld_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_pop,
    input  wire t_word_op i_op,
    output logic [2:0]    o_byte_kind,
    output logic [7:0]    o_out_byte,
    output logic [7:0]    o_channel_id,
    output logic [15:0]   o_packet_length,
    output logic [15:0]   o_command_spec,
    output logic [15:0]   o_command_ref,
    output logic [7:0]    o_priority_level,
    output logic [15:0]   o_data_length,
    output logic [31:0]   o_consumed_count,
    output logic          o_extended_format,
    output logic          o_header_done,
    output logic          o_last_of_packet
);

    logic [7:0]  r_chan, n_chan;
    logic [15:0] r_len, n_len;
    logic [15:0] r_spec, n_spec;
    logic [15:0] r_ref, n_ref;
    logic [7:0]  r_prio, n_prio;
    logic [15:0] r_dlen, n_dlen;
    logic [31:0] r_cons, n_cons;
    logic        r_ext, n_ext;
    t_kind       r_kind;
    logic [7:0]  r_byte;
    logic        r_hdone;
    logic        r_last;

    always_comb begin
        n_chan = r_chan;
        n_len  = r_len;
        n_spec = r_spec;
        n_ref  = r_ref;
        n_prio = r_prio;
        n_dlen = r_dlen;
        n_cons = r_cons;
        n_ext  = r_ext | i_op.set_ext;
        unique case (i_op.op)
            OP_NONE:       n_chan = r_chan;
            OP_CLEAR: begin
                n_chan = 8'd0;
                n_len  = 16'd0;
                n_spec = 16'd0;
                n_ref  = 16'd0;
                n_prio = 8'd0;
                n_dlen = 16'd0;
                n_cons = 32'd0;
                n_ext  = 1'b0;
            end
            OP_CHAN:       n_chan = i_op.data;
            OP_LEN:        n_len  = {r_len[7:0], i_op.data};
            OP_SPEC:       n_spec = {r_spec[7:0], i_op.data};
            OP_REF:        n_ref  = {r_ref[7:0], i_op.data};
            OP_PRIO:       n_prio = i_op.data;
            OP_DLEN_SHIFT: n_dlen = {r_dlen[7:0], i_op.data};
            OP_DLEN_LOAD:  n_dlen = i_op.value;
            OP_CONS:       n_cons = {r_cons[23:0], i_op.data};
            default:       n_chan = r_chan;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            r_kind <= i_op.kind;
            r_byte <= i_op.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan  <= 8'd0;
            r_len   <= 16'd0;
            r_spec  <= 16'd0;
            r_ref   <= 16'd0;
            r_prio  <= 8'd0;
            r_dlen  <= 16'd0;
            r_cons  <= 32'd0;
            r_ext   <= 1'b0;
            r_hdone <= 1'b0;
            r_last  <= 1'b0;
        end else if (i_pop) begin
            r_chan  <= n_chan;
            r_len   <= n_len;
            r_spec  <= n_spec;
            r_ref   <= n_ref;
            r_prio  <= n_prio;
            r_dlen  <= n_dlen;
            r_cons  <= n_cons;
            r_ext   <= n_ext;
            r_hdone <= i_op.hdone;
            r_last  <= i_op.last;
        end
    end

    assign o_byte_kind       = r_kind;
    assign o_out_byte        = r_byte;
    assign o_channel_id      = r_chan;
    assign o_packet_length   = r_len;
    assign o_command_spec    = r_spec;
    assign o_command_ref     = r_ref;
    assign o_priority_level  = r_prio;
    assign o_data_length     = r_dlen;
    assign o_consumed_count  = r_cons;
    assign o_extended_format = r_ext;
    assign o_header_done     = r_hdone;
    assign o_last_of_packet  = r_last;

endmodule

`default_nettype wire

### sv/printer_link_packet_deframer_unit.sv
// printer link packet deframer, top level: front, two-word queue, back
// an accepted input word is registered in the queue, then in the back's result registers when the output is free
// throughput: one word per cycle while the queue is not full; the front phase updates once per accepted word
// the two-word queue absorbs an output stall while the front keeps accepting
// reset (synchronous, active low) returns to waiting for a mark with all header fields zero
`timescale 1ns / 1ps
`default_nettype none

module printer_link_packet_deframer_unit
    import pld_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_byte_kind,
    output logic [7:0]       o_out_byte,
    output logic [7:0]       o_channel_id,
    output logic [15:0]      o_packet_length,
    output logic [15:0]      o_command_spec,
    output logic [15:0]      o_command_ref,
    output logic [7:0]       o_priority_level,
    output logic [15:0]      o_data_length,
    output logic [31:0]      o_consumed_count,
    output logic             o_extended_format,
    output logic             o_header_done,
    output logic             o_last_of_packet
);

    t_word_op w_front_op;
    t_word_op w_q_op;
    logic     w_push;
    logic     w_pop;
    logic     w_q_valid;
    logic     w_q_full;
    logic     r_out_valid;

    assign o_in_stall  = w_q_full;
    assign w_push      = i_in_valid && !w_q_full;
    assign w_pop       = w_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;

    pld_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_byte  (i_in_byte),
        .o_op    (w_front_op)
    );

    pld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_op),
        .i_pop   (w_pop),
        .o_data  (w_q_op),
        .o_valid (w_q_valid),
        .o_full  (w_q_full)
    );

    pld_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_pop             (w_pop),
        .i_op              (w_q_op),
        .o_byte_kind       (o_byte_kind),
        .o_out_byte        (o_out_byte),
        .o_channel_id      (o_channel_id),
        .o_packet_length   (o_packet_length),
        .o_command_spec    (o_command_spec),
        .o_command_ref     (o_command_ref),
        .o_priority_level  (o_priority_level),
        .o_data_length     (o_data_length),
        .o_consumed_count  (o_consumed_count),
        .o_extended_format (o_extended_format),
        .o_header_done     (o_header_done),
        .o_last_of_packet  (o_last_of_packet)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // sync error is sticky until reset
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_byte_kind == KIND_SYNC_ERR))
        |=> (!o_out_valid || (o_byte_kind == KIND_SYNC_ERR)))
        else $error("word after a sync error not classed as error");

    // an error word never completes a header or a packet
    a_err_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_byte_kind == KIND_SYNC_ERR))
        |-> (!o_header_done && !o_last_of_packet))
        else $error("error word with header or packet flags");

    // header completion only on length, header or extended header words
    a_hdone_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_header_done)
        |-> ((o_byte_kind == KIND_LEN) || (o_byte_kind == KIND_HDR)
             || (o_byte_kind == KIND_EXT)))
        else $error("header done on a wrong word kind");

    // a mark clears every packet field; the channel, length, consumed count and extended flag are checked
    a_mark_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_byte_kind == KIND_MARK))
        |-> ((o_channel_id == 8'd0) && (o_packet_length == 16'd0)
             && (o_consumed_count == 32'd0) && !o_extended_format))
        else $error("packet fields not cleared on mark");

endmodule

`default_nettype wire

### sim/tb_printer_link_packet_deframer_unit.sv
// testbench for printer_link_packet_deframer_unit: a byte-level predictor of the deframer
// checks every result word; stimulus is directed packets, random packets and a sync error
// depends on pld_pkg and printer_link_packet_deframer_unit
`timescale 1ns / 1ps

module tb_printer_link_packet_deframer_unit;

    import pld_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [7:0]  chan;
        logic [15:0] plen;
        logic [15:0] spec;
        logic [15:0] cref;
        logic [7:0]  prio;
        logic [15:0] dlen;
        logic [31:0] consumed;
        logic        ext;
        logic        hdone;
        logic        last;
    } t_byte_report;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_in_byte   = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_byte_kind;
    logic [7:0]  o_out_byte;
    logic [7:0]  o_channel_id;
    logic [15:0] o_packet_length;
    logic [15:0] o_command_spec;
    logic [15:0] o_command_ref;
    logic [7:0]  o_priority_level;
    logic [15:0] o_data_length;
    logic [31:0] o_consumed_count;
    logic        o_extended_format;
    logic        o_header_done;
    logic        o_last_of_packet;

    printer_link_packet_deframer_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_in_byte         (i_in_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_byte_kind       (o_byte_kind),
        .o_out_byte        (o_out_byte),
        .o_channel_id      (o_channel_id),
        .o_packet_length   (o_packet_length),
        .o_command_spec    (o_command_spec),
        .o_command_ref     (o_command_ref),
        .o_priority_level  (o_priority_level),
        .o_data_length     (o_data_length),
        .o_consumed_count  (o_consumed_count),
        .o_extended_format (o_extended_format),
        .o_header_done     (o_header_done),
        .o_last_of_packet  (o_last_of_packet)
    );

    always #5 i_clk = ~i_clk;

    // deframer state as the predictor sees it
    t_phase      ph       = PH_MARK;
    logic [3:0]  fld_cnt  = '0;
    logic [15:0] left_q   = '0;
    logic [7:0]  chan_q   = '0;
    logic [15:0] len_q    = '0;
    logic [15:0] spec_q   = '0;
    logic [15:0] ref_q    = '0;
    logic [7:0]  prio_q   = '0;
    logic [15:0] dlen_q   = '0;
    logic [31:0] cons_q   = '0;
    logic        ext_q    = 1'b0;

    t_byte_report byte_reports_due[$];
    int           mismatch_count  = 0;
    int           bytes_accepted  = 0;
    bit           sender_gaps     = 1'b1;
    bit           receiver_stalls = 1'b1;
    int           long_hold       = 0;
    int           stall_left      = 0;

    function automatic logic open_payload(input t_phase nxt, input logic [15:0] count);
        if (count == 16'd0) begin
            ph     = PH_MARK;
            left_q = '0;
            return 1'b1;
        end
        ph     = nxt;
        left_q = count;
        return 1'b0;
    endfunction

    function automatic t_byte_report classify_byte(input logic [7:0] b);
        t_byte_report r;
        logic [15:0]  body;
        logic [15:0]  count;
        r      = '0;
        r.kind = KIND_SYNC_ERR;
        case (ph)
            PH_MARK: begin
                if (b == MARK_BYTE) begin
                    r.kind  = KIND_MARK;
                    chan_q  = '0;
                    len_q   = '0;
                    spec_q  = '0;
                    ref_q   = '0;
                    prio_q  = '0;
                    dlen_q  = '0;
                    cons_q  = '0;
                    ext_q   = 1'b0;
                    fld_cnt = '0;
                    left_q  = '0;
                    ph      = PH_CHAN;
                end else begin
                    ph = PH_ERR;
                end
            end
            PH_CHAN: begin
                r.kind  = KIND_CHAN;
                chan_q  = b;
                fld_cnt = '0;
                ph      = PH_LEN;
            end
            PH_LEN: begin
                r.kind = KIND_LEN;
                len_q  = {len_q[7:0], b};
                if (fld_cnt == 4'd0) begin
                    fld_cnt = 4'd1;
                end else begin
                    fld_cnt = '0;
                    if (chan_q == CMD_CHANNEL && len_q >= HDR_BYTES) begin
                        ph = PH_HDR;
                    end else begin
                        r.hdone = 1'b1;
                        r.last  = open_payload(PH_RAW, len_q);
                    end
                end
            end
            PH_HDR: begin
                r.kind = KIND_HDR;
                case (fld_cnt[2:0])
                    3'd0, 3'd1: spec_q = {spec_q[7:0], b};
                    3'd2, 3'd3: ref_q  = {ref_q[7:0], b};
                    3'd4:       prio_q = b;
                    3'd5:       ;
                    default:    dlen_q = {dlen_q[7:0], b};
                endcase
                if (fld_cnt >= 4'd7) begin
                    body    = len_q - HDR_BYTES;
                    fld_cnt = '0;
                    if (dlen_q != body || spec_q == SPEC_EXTENDED) begin
                        ext_q = 1'b1;
                        ph    = PH_EXT;
                    end else begin
                        dlen_q  = body;
                        r.hdone = 1'b1;
                        r.last  = open_payload(PH_CMD, body);
                    end
                end else begin
                    fld_cnt = fld_cnt + 4'd1;
                end
            end
            PH_EXT: begin
                r.kind = KIND_EXT;
                if (fld_cnt < 4'd4)
                    cons_q = {cons_q[23:0], b};
                if (fld_cnt >= 4'd7) begin
                    count   = (len_q >= EXT_HDR_TOTAL) ? len_q - EXT_HDR_TOTAL : 16'd0;
                    dlen_q  = count;
                    fld_cnt = '0;
                    r.hdone = 1'b1;
                    r.last  = open_payload(PH_CMD, count);
                end else begin
                    fld_cnt = fld_cnt + 4'd1;
                end
            end
            PH_CMD, PH_RAW: begin
                r.kind = (ph == PH_CMD) ? KIND_CMD : KIND_RAW;
                if (left_q <= 16'd1) begin
                    left_q = '0;
                    ph     = PH_MARK;
                    r.last = 1'b1;
                end else begin
                    left_q = left_q - 16'd1;
                end
            end
            default: ph = PH_ERR;
        endcase
        r.data     = b;
        r.chan     = chan_q;
        r.plen     = len_q;
        r.spec     = spec_q;
        r.cref     = ref_q;
        r.prio     = prio_q;
        r.dlen     = dlen_q;
        r.consumed = cons_q;
        r.ext      = ext_q;
        return r;
    endfunction

    function automatic string report_text(input t_byte_report r);
        return {$sformatf("kind %0d byte %02h chan %02h len %04h spec %04h ref %04h ",
                          r.kind, r.data, r.chan, r.plen, r.spec, r.cref),
                $sformatf("prio %02h dlen %04h cons %08h ext %b hdone %b last %b",
                          r.prio, r.dlen, r.consumed, r.ext, r.hdone, r.last)};
    endfunction

    // receiver: random stall before each word, plus an optional long hold
    always @(posedge i_clk) begin
        if (long_hold > 0) begin
            i_out_stall <= 1'b1;
            long_hold = long_hold - 1;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (o_out_valid && !i_out_stall)
                stall_left = receiver_stalls ? $urandom_range(0, 8) : 0;
        end
    end

    always @(posedge i_clk) begin
        t_byte_report got;
        t_byte_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.kind     = t_kind'(o_byte_kind);
            got.data     = o_out_byte;
            got.chan     = o_channel_id;
            got.plen     = o_packet_length;
            got.spec     = o_command_spec;
            got.cref     = o_command_ref;
            got.prio     = o_priority_level;
            got.dlen     = o_data_length;
            got.consumed = o_consumed_count;
            got.ext      = o_extended_format;
            got.hdone    = o_header_done;
            got.last     = o_last_of_packet;
            if (byte_reports_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result word with nothing due: %s", report_text(got));
            end else begin
                want = byte_reports_due.pop_front();
                if (got.kind !== want.kind || got.data !== want.data
                    || got.chan !== want.chan || got.plen !== want.plen
                    || got.spec !== want.spec || got.cref !== want.cref
                    || got.prio !== want.prio || got.dlen !== want.dlen
                    || got.consumed !== want.consumed || got.ext !== want.ext
                    || got.hdone !== want.hdone || got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", report_text(want));
                        $display("  actual   %s", report_text(got));
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        bytes_accepted++;
        byte_reports_due.push_back(classify_byte(b));
    endtask

    task automatic send_packet(input logic [7:0] chan, input logic [15:0] plen,
                               input logic [15:0] spec, input logic [15:0] cref,
                               input logic [7:0] prio, input logic [7:0] spare,
                               input logic [15:0] dlen, input logic [63:0] ext_block);
        logic [63:0] hdr;
        int          n;
        hdr = {spec, cref, prio, spare, dlen};
        send_byte(MARK_BYTE);
        send_byte(chan);
        send_byte(plen[15:8]);
        send_byte(plen[7:0]);
        if (chan == CMD_CHANNEL && plen >= HDR_BYTES) begin
            for (int i = 7; i >= 0; i--)
                send_byte(hdr[i*8 +: 8]);
            if (dlen != plen - HDR_BYTES || spec == SPEC_EXTENDED) begin
                for (int i = 7; i >= 0; i--)
                    send_byte(ext_block[i*8 +: 8]);
                n = (plen >= EXT_HDR_TOTAL) ? plen - EXT_HDR_TOTAL : 0;
            end else begin
                n = plen - HDR_BYTES;
            end
        end else begin
            n = plen;
        end
        // payload, with marks sprinkled in that must not restart framing
        repeat (n)
            send_byte(($urandom_range(0, 7) == 0) ? MARK_BYTE : 8'($urandom));
    endtask

    task automatic send_random_packet();
        int          sel;
        logic [7:0]  chan;
        logic [15:0] plen;
        logic [15:0] spec;
        logic [15:0] dlen;
        sel  = $urandom_range(0, 39);
        spec = 16'($urandom);
        dlen = 16'($urandom);
        chan = CMD_CHANNEL;
        if (sel < 16) begin
            // command packet whose header agrees with the link length
            plen = HDR_BYTES + 16'($urandom_range(0, 32));
            if (spec == SPEC_EXTENDED)
                spec = '0;
            dlen = plen - HDR_BYTES;
        end else if (sel < 28) begin
            // extended format, forced by the specifier or a length disagreement
            plen = 16'($urandom_range(8, 48));
            case ($urandom_range(0, 2))
                0: begin
                    spec = SPEC_EXTENDED;
                    dlen = plen - HDR_BYTES;
                end
                1: dlen = plen - HDR_BYTES + 16'($urandom_range(1, 3));
                default: ;
            endcase
        end else if (sel < 32) begin
            // command channel too short for a header
            plen = 16'($urandom_range(0, 7));
        end else if (sel < 39) begin
            chan = 8'($urandom_range(2, 255));
            plen = 16'($urandom_range(0, 32));
        end else begin
            chan = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hFF;
            plen = 16'($urandom_range(100, 300));
        end
        sender_gaps     = ($urandom_range(0, 3) != 0);
        receiver_stalls = ($urandom_range(0, 3) != 0);
        send_packet(chan, plen, spec, 16'($urandom), 8'($urandom), 8'($urandom), dlen,
                    {$urandom, $urandom});
    endtask

    task automatic test_raw_framing();
        send_packet(8'h00, 16'd0, '0, '0, '0, '0, '0, '0);
        send_packet(CMD_CHANNEL, 16'd7, '0, '0, '0, '0, '0, '0);
    endtask

    task automatic test_command_header();
        // empty command payload (data length zero), all other header fields at their maximum
        send_packet(CMD_CHANNEL, HDR_BYTES, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'h0000, '0);
    endtask

    task automatic test_extended_header();
        // extended specifier on a packet too short for an extended block
        send_packet(CMD_CHANNEL, 16'd12, SPEC_EXTENDED, 16'h0000, 8'h00, 8'h00, 16'h0004,
                    64'hFFFF_FFFF_0000_0000);
    endtask

    task automatic test_output_backpressure();
        sender_gaps = 1'b0;
        long_hold   = 80;
        send_packet(8'h02, 16'd24, '0, '0, '0, '0, '0, '0);
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_stream();
        while (bytes_accepted < 1750)
            send_random_packet();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    task automatic test_sync_error();
        // a missing mark locks the block in the error state, later marks included
        send_byte(8'hA5);
        send_byte(MARK_BYTE);
        send_byte(8'h00);
        send_byte(8'hFF);
        repeat (12)
            send_byte(($urandom_range(0, 3) == 0) ? MARK_BYTE : 8'($urandom));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_raw_framing();
        test_command_header();
        test_extended_header();
        test_output_backpressure();
        test_random_stream();
        test_sync_error();
        i_in_valid <= 1'b0;
        while (byte_reports_due.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && byte_reports_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
sv/pld_pkg.sv
sv/pld_front.sv
sv/pld_queue.sv
sv/pld_back.sv
sv/printer_link_packet_deframer_unit.sv
sim/tb_printer_link_packet_deframer_unit.sv
